// ===== sv/accel_tilt_angle_freefall_macros.svh =====
// Assertion macros for the tilt angle and free-fall block
`ifndef ACCEL_TILT_ANGLE_FREEFALL_MACROS_SVH
`define ACCEL_TILT_ANGLE_FREEFALL_MACROS_SVH
`ifndef SYNTHESIS
`define ATF_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ATF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATF_ASSERT_HOLD(label, cond, msg)
`define ATF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/atf_pkg.sv =====
// Types, constants and the arctangent table for the tilt angle block
`timescale 1ns / 1ps
package atf_pkg;

  localparam int SQRT_STEPS    = 32;
  localparam int CORDIC_STAGES = 24;
  localparam int VEC_W         = 36;
  localparam int CANG_W        = 32;
  localparam int ANG_W         = 34;
  localparam int PITCH_W       = 15;
  localparam int ROLL_W        = 16;

  localparam logic [15:0] PITCH_LIM  = 16'd9000;
  localparam logic [15:0] ROLL_LIM   = 16'd18000;
  localparam logic [15:0] CENTI_TURN = 16'd36000;
  localparam logic [15:0] THR_RESET  = 16'd4915;
  localparam logic signed [ANG_W-1:0] HALF_TURN = 34'sh0_8000_0000;

  // atan(2^-i), 2^32 units per turn
  localparam logic [CANG_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [2:0] {
    ROLL_NORM     = 3'd0,
    ROLL_FLIP_POS = 3'd1,
    ROLL_FLIP_NEG = 3'd2,
    ROLL_ZERO     = 3'd3,
    ROLL_NEG_HALF = 3'd4
  } roll_mode_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } atf_in_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_centideg;
    logic signed [ROLL_W-1:0]  roll_centideg;
    logic                      free_fall;
  } atf_out_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } atf_sq_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0]        mag2;
  } atf_sqside_t;

  typedef struct packed {
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic signed [CANG_W-1:0] ang;
  } atf_vec_t;

  typedef struct packed {
    roll_mode_t mode;
    logic       pitch_zero;
    logic       ff;
  } atf_cside_t;

endpackage

// ===== sv/atf_sqrt_cell.sv =====
// One digit step of the pipelined square root
`timescale 1ns / 1ps
module atf_sqrt_cell import atf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  atf_sq_t     sq_i,
  input  atf_sqside_t side_i,
  output logic        vld_o,
  output atf_sq_t     sq_o,
  output atf_sqside_t side_o
);

  logic [33:0] rem_sh;
  logic [33:0] trial;
  atf_sq_t     sq_nxt;
  atf_sq_t     sq_r;
  atf_sqside_t side_r;
  logic        vld_r;

  always_comb begin
    rem_sh     = {sq_i.rem[31:0], sq_i.rad[63:62]};
    trial      = {sq_i.root, 2'b01};
    sq_nxt.rad = {sq_i.rad[61:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_nxt.rem  = rem_sh - trial;
      sq_nxt.root = {sq_i.root[30:0], 1'b1};
    end else begin
      sq_nxt.rem  = rem_sh;
      sq_nxt.root = {sq_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= sq_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign sq_o   = sq_r;
  assign side_o = side_r;

endmodule

// ===== sv/atf_cordic_cell.sv =====
// One vectoring CORDIC iteration for the pitch and roll lanes
`timescale 1ns / 1ps
module atf_cordic_cell import atf_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vld_i,
  input  atf_vec_t   p_i,
  input  atf_vec_t   r_i,
  input  atf_cside_t side_i,
  output logic       vld_o,
  output atf_vec_t   p_o,
  output atf_vec_t   r_o,
  output atf_cside_t side_o
);

  localparam logic signed [CANG_W-1:0] ATAN_C = $signed(ATAN_TAB[IDX]);

  function automatic atf_vec_t rot(input atf_vec_t v);
    atf_vec_t                w;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    xs = $signed(v.vx) >>> IDX;
    ys = $signed(v.vy) >>> IDX;
    if ($signed(v.vy) > 0) begin
      w.vx  = v.vx + ys;
      w.vy  = v.vy - xs;
      w.ang = v.ang + ATAN_C;
    end else begin
      w.vx  = v.vx - ys;
      w.vy  = v.vy + xs;
      w.ang = v.ang - ATAN_C;
    end
    return w;
  endfunction

  atf_vec_t   p_nxt;
  atf_vec_t   r_nxt;
  atf_vec_t   p_r;
  atf_vec_t   r_r;
  atf_cside_t side_r;
  logic       vld_r;

  assign p_nxt = rot(p_i);
  assign r_nxt = rot(r_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_nxt;
      r_r    <= r_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign p_o    = p_r;
  assign r_o    = r_r;
  assign side_o = side_r;

endmodule

// ===== sv/atf_conv.sv =====
// Binary angle to rounded, clamped centidegrees, two stages
`timescale 1ns / 1ps
module atf_conv import atf_pkg::*; #(
  parameter int          OUT_W = ROLL_W,
  parameter logic [15:0] LIMIT = ROLL_LIM
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] ang_i,
  output logic [OUT_W-1:0]        val_o
);

  logic signed [ANG_W-1:0] abs_v;
  logic [47:0]             prod_nxt;
  logic [47:0]             prod_r;
  logic                    neg_r;
  logic [47:0]             rnd;
  logic [15:0]             cen;
  logic [15:0]             clp;
  logic [16:0]             res;
  logic [OUT_W-1:0]        val_r;

  always_comb begin
    abs_v    = ang_i[ANG_W-1] ? -ang_i : ang_i;
    prod_nxt = 48'(abs_v[31:0]) * 48'(CENTI_TURN);
  end

  always_comb begin
    rnd = prod_r + 48'h0000_8000_0000;
    cen = rnd[47:32];
    clp = (cen > LIMIT) ? LIMIT : cen;
    res = neg_r ? (17'd0 - {1'b0, clp}) : {1'b0, clp};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      neg_r  <= ang_i[ANG_W-1];
      val_r  <= res[OUT_W-1:0];
    end
  end

  assign val_o = val_r;

endmodule

// ===== sv/accel_tilt_angle_freefall.sv =====
// Top level: pitch, roll and free-fall flag from one accelerometer sample
//
//   channel | ports                         | word
//   --------+-------------------------------+--------------------------------
//   in      | in_valid, in_stall, in_word   | accel_x, accel_y, accel_z
//   out     | out_valid, out_stall, out_word| pitch_centideg, roll_centideg,
//           |                               | free_fall
//   cfg     | cfg_we, cfg_wdata             | freefall_threshold
//
// One word per cycle while in_stall is low. Each word passes through
// the 32 square root cells and the 24 CORDIC cells, plus seven single
// registers around them, the output register included.
// Reset clears the valid bits and the output and skid flags, and loads the
// default threshold.
// A stalled output parks one more word in a skid register; the chain then
// freezes and in_stall stays high until the skid word leaves.
`timescale 1ns / 1ps
`include "accel_tilt_angle_freefall_macros.svh"
module accel_tilt_angle_freefall import atf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  atf_in_t     in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output atf_out_t    out_word,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic adv;

  // threshold
  logic [15:0] thr_r;
  logic [31:0] thr_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= 32'(thr_r) * 32'(thr_r);
  end

  // squares
  logic signed [31:0] xx_nxt;
  logic signed [31:0] yy_nxt;
  logic signed [31:0] zz_nxt;
  logic               vld_s0_r;
  atf_in_t            smp_s0_r;
  logic [30:0]        xx_r;
  logic [30:0]        yy_r;
  logic [30:0]        zz_r;

  assign xx_nxt = 32'(in_word.accel_x) * 32'(in_word.accel_x);
  assign yy_nxt = 32'(in_word.accel_y) * 32'(in_word.accel_y);
  assign zz_nxt = 32'(in_word.accel_z) * 32'(in_word.accel_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s0_r <= 1'b0;
    end else if (adv) begin
      vld_s0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp_s0_r <= in_word;
      xx_r     <= xx_nxt[30:0];
      yy_r     <= yy_nxt[30:0];
      zz_r     <= zz_nxt[30:0];
    end
  end

  // sums
  logic        vld_s1_r;
  atf_in_t     smp_s1_r;
  logic [31:0] rxz2_r;
  logic [31:0] mag2_r;
  logic [31:0] rxz2_nxt;

  assign rxz2_nxt = {1'b0, xx_r} + {1'b0, zz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
    end else if (adv) begin
      vld_s1_r <= vld_s0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp_s1_r <= smp_s0_r;
      rxz2_r   <= rxz2_nxt;
      mag2_r   <= rxz2_nxt + {1'b0, yy_r};
    end
  end

  // square root chain
  logic        sq_vld  [SQRT_STEPS+1];
  atf_sq_t     sq      [SQRT_STEPS+1];
  atf_sqside_t sq_side [SQRT_STEPS+1];

  assign sq_vld[0]       = vld_s1_r;
  assign sq[0].rad       = {rxz2_r, 32'd0};
  assign sq[0].rem       = '0;
  assign sq[0].root      = '0;
  assign sq_side[0].x    = smp_s1_r.accel_x;
  assign sq_side[0].y    = smp_s1_r.accel_y;
  assign sq_side[0].z    = smp_s1_r.accel_z;
  assign sq_side[0].mag2 = mag2_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    atf_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (sq_vld[i]),
      .sq_i   (sq[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .sq_o   (sq[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // CORDIC setup
  atf_sqside_t             ps;
  logic [31:0]             p_root;
  logic signed [VEC_W-1:0] x16;
  logic signed [VEC_W-1:0] y16;
  logic signed [VEC_W-1:0] z16;
  atf_vec_t                pv_nxt;
  atf_vec_t                rv_nxt;
  atf_cside_t              cs_nxt;
  logic                    vld_p_r;
  atf_vec_t                pv_r;
  atf_vec_t                rv_r;
  atf_cside_t              cs_r;

  always_comb begin
    ps     = sq_side[SQRT_STEPS];
    p_root = sq[SQRT_STEPS].root;
    x16    = {{4{ps.x[15]}}, ps.x, 16'd0};
    y16    = {{4{ps.y[15]}}, ps.y, 16'd0};
    z16    = {{4{ps.z[15]}}, ps.z, 16'd0};
    pv_nxt.vx  = {4'd0, p_root};
    pv_nxt.vy  = y16;
    pv_nxt.ang = '0;
    rv_nxt     = '0;
    cs_nxt.pitch_zero = (p_root == '0) && (ps.y == '0);
    cs_nxt.ff         = ps.mag2 < thr_sq_r;
    if (ps.x == '0) begin
      cs_nxt.mode = ps.z[15] ? ROLL_NEG_HALF : ROLL_ZERO;
    end else if (ps.z[15]) begin
      rv_nxt.vx   = -z16;
      rv_nxt.vy   = x16;
      cs_nxt.mode = ps.x[15] ? ROLL_FLIP_POS : ROLL_FLIP_NEG;
    end else begin
      rv_nxt.vx   = z16;
      rv_nxt.vy   = -x16;
      cs_nxt.mode = ROLL_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r <= 1'b0;
    end else if (adv) begin
      vld_p_r <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pv_r <= pv_nxt;
      rv_r <= rv_nxt;
      cs_r <= cs_nxt;
    end
  end

  // CORDIC chain
  logic       cv_vld [CORDIC_STAGES+1];
  atf_vec_t   cv_p   [CORDIC_STAGES+1];
  atf_vec_t   cv_r   [CORDIC_STAGES+1];
  atf_cside_t cv_s   [CORDIC_STAGES+1];

  assign cv_vld[0] = vld_p_r;
  assign cv_p[0]   = pv_r;
  assign cv_r[0]   = rv_r;
  assign cv_s[0]   = cs_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    atf_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (cv_vld[i]),
      .p_i    (cv_p[i]),
      .r_i    (cv_r[i]),
      .side_i (cv_s[i]),
      .vld_o  (cv_vld[i+1]),
      .p_o    (cv_p[i+1]),
      .r_o    (cv_r[i+1]),
      .side_o (cv_s[i+1])
    );
  end

  // quadrant fix-up
  atf_cside_t              cf;
  logic signed [ANG_W-1:0] pa_ext;
  logic signed [ANG_W-1:0] ra_ext;
  logic signed [ANG_W-1:0] pang_nxt;
  logic signed [ANG_W-1:0] rang_nxt;
  logic                    vld_a_r;
  logic                    ff_a_r;
  logic signed [ANG_W-1:0] pang_r;
  logic signed [ANG_W-1:0] rang_r;

  always_comb begin
    cf       = cv_s[CORDIC_STAGES];
    pa_ext   = {{2{cv_p[CORDIC_STAGES].ang[CANG_W-1]}}, cv_p[CORDIC_STAGES].ang};
    ra_ext   = {{2{cv_r[CORDIC_STAGES].ang[CANG_W-1]}}, cv_r[CORDIC_STAGES].ang};
    pang_nxt = cf.pitch_zero ? '0 : pa_ext;
    case (cf.mode)
      ROLL_NORM:     rang_nxt = ra_ext;
      ROLL_FLIP_POS: rang_nxt = ra_ext + HALF_TURN;
      ROLL_FLIP_NEG: rang_nxt = ra_ext - HALF_TURN;
      ROLL_NEG_HALF: rang_nxt = -HALF_TURN;
      ROLL_ZERO:     rang_nxt = '0;
      default:       rang_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= cv_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ff_a_r <= cf.ff;
      pang_r <= pang_nxt;
      rang_r <= rang_nxt;
    end
  end

  // centidegree conversion
  logic               vld_m_r;
  logic               vld_q_r;
  logic               ff_m_r;
  logic               ff_q_r;
  logic [PITCH_W-1:0] pitch_val;
  logic [ROLL_W-1:0]  roll_val;

  atf_conv #(
    .OUT_W (PITCH_W),
    .LIMIT (PITCH_LIM)
  ) u_conv_pitch (
    .clk   (clk),
    .en    (adv),
    .ang_i (pang_r),
    .val_o (pitch_val)
  );

  atf_conv #(
    .OUT_W (ROLL_W),
    .LIMIT (ROLL_LIM)
  ) u_conv_roll (
    .clk   (clk),
    .en    (adv),
    .ang_i (rang_r),
    .val_o (roll_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
      vld_q_r <= 1'b0;
    end else if (adv) begin
      vld_m_r <= vld_a_r;
      vld_q_r <= vld_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ff_m_r <= ff_a_r;
      ff_q_r <= ff_m_r;
    end
  end

  // output register and skid
  atf_out_t last_word;
  atf_out_t out_word_r;
  atf_out_t skid_word_r;
  logic     out_valid_r;
  logic     skid_valid_r;
  logic     out_fire;

  assign last_word.pitch_centideg = pitch_val;
  assign last_word.roll_centideg  = roll_val;
  assign last_word.free_fall      = ff_q_r;

  assign out_fire = out_valid_r && !out_stall;
  assign adv      = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_valid_r <= vld_q_r;
    end else if (vld_q_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_word_r <= skid_word_r;
      end
    end else if (!out_valid_r || out_fire) begin
      out_word_r <= last_word;
    end else begin
      skid_word_r <= last_word;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `ATF_ASSERT_HOLD(a_skid_behind_out, !skid_valid_r || out_valid_r,
                   "skid word without output word")
  `ATF_ASSERT_NEXT(a_chain_frozen, skid_valid_r, $stable(vld_a_r) && $stable(vld_q_r),
                   "chain moved while skid full")
  `ATF_ASSERT_HOLD(a_pitch_range,
                   !out_valid_r || ($signed(out_word_r.pitch_centideg) <= 15'sd9000 &&
                                    $signed(out_word_r.pitch_centideg) >= -15'sd9000),
                   "pitch out of range")
  `ATF_ASSERT_HOLD(a_roll_range,
                   !out_valid_r || ($signed(out_word_r.roll_centideg) <= 16'sd18000 &&
                                    $signed(out_word_r.roll_centideg) >= -16'sd18000),
                   "roll out of range")

endmodule
